@@ src/pclb_pkg.sv @@
// Shared types and constants for the particle cell-list binning unit.
// No dependencies; every other file of the block but pclb_fifo imports this package.
`default_nettype none

package pclb_pkg;

  // Fixed field widths of the command and result channels.
  localparam int CMD_W  = 2;
  localparam int PID_W  = 10;
  localparam int POS_W  = 16;
  localparam int QC_W   = 12;
  localparam int CIDX_W = 12;
  localparam int CNT_W  = 11;
  localparam int CFG_W  = 5;

  // Reset value of the cells-per-side register.
  localparam logic [CFG_W-1:0] SIDE_RESET = 5'd16;

  // Per-cell counts stop at this value.
  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

  // Frame tag stored with every cell entry; tag zero never matches.
  localparam int EPOCH_W = 6;

  // Depth of the queue between the classifier and the store unit.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_READ_CELL = 2'd1,
    CMD_READ_LINK = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_e;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    cmd_e              cmd;
    logic              new_frame;
    logic [PID_W-1:0]  pid;
    logic              pid_ok;
    logic [QC_W-1:0]   query_cell;
    logic              query_ok;
  } bin_op_t;

endpackage

`default_nettype wire

@@ src/pclb_front.sv @@
// Front part: accepts commands, classifies them and computes the cell index.
// Depends on pclb_pkg; feeds the command queue (pclb_fifo).
`default_nettype none

module pclb_front #(
  parameter int MAX_SIDE = 16,
  parameter int MAX_PARTICLES = 1024,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1),
  localparam int NUM_CELLS = MAX_SIDE * MAX_SIDE * MAX_SIDE,
  localparam int CELL_AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [pclb_pkg::CMD_W-1:0]    cmd,
  input  wire logic                          new_frame,
  input  wire logic [pclb_pkg::PID_W-1:0]    particle_id,
  input  wire logic signed [pclb_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [pclb_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [pclb_pkg::POS_W-1:0] pos_z,
  input  wire logic [pclb_pkg::QC_W-1:0]     query_cell,
  input  wire logic [SIDE_W-1:0]             side,
  output logic                               q_push,
  input  wire logic                          q_full,
  output pclb_pkg::bin_op_t                  q_op,
  output logic [CELL_AW-1:0]                 q_addr
);
  import pclb_pkg::*;

  localparam int AX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SQ_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;

  // Map one signed Q1.15 coordinate to its cell along an axis.
  function automatic logic [AX_W-1:0] axis_cell(input logic [POS_W-1:0] raw,
                                                input logic [SIDE_W-1:0] s);
    logic [POS_W-1:0]        biased;
    logic [POS_W+SIDE_W-1:0] prod;
    logic [SIDE_W-1:0]       c;
    biased = {~raw[POS_W-1], raw[POS_W-2:0]};
    prod   = biased * s;
    c      = prod[POS_W+SIDE_W-1:POS_W];
    if (c > s - 1'b1) begin
      c = s - 1'b1;
    end
    return AX_W'(c);
  endfunction

  logic                  adv;
  logic                  v1, v2, v3;
  bin_op_t               op1, op2, op3;
  logic [AX_W-1:0]       cx1, cy1, cz1, cz2;
  logic [SQ_W-1:0]       t2;
  logic [CELL_AW-1:0]    addr3;
  logic [AX_W+SIDE_W-1:0] mul_x;
  logic [SQ_W+SIDE_W-1:0] mul_t;
  logic [CELL_AW-1:0]    cell_next;
  bin_op_t               op_in;

  // The whole pipeline moves unless the last stage holds a command it cannot hand on.
  assign adv    = !v3 || !q_full;
  assign full   = !adv;
  assign q_push = v3 && !q_full;
  assign q_op   = op3;
  assign q_addr = addr3;

  // Classify the incoming command: range checks on the particle and the cell.
  always_comb begin
    op_in.cmd        = cmd_e'(cmd);
    op_in.new_frame  = new_frame;
    op_in.pid        = particle_id;
    op_in.pid_ok     = int'(particle_id) < MAX_PARTICLES;
    op_in.query_cell = query_cell;
    op_in.query_ok   = int'(query_cell) < NUM_CELLS;
  end

  // Row-major index products, each behind its own register.
  assign mul_x     = cx1 * side;
  assign mul_t     = t2 * side;
  assign cell_next = CELL_AW'(mul_t) + CELL_AW'(cz2);

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage payloads: axis cells, partial index, final address.
  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= op_in;
      cx1 <= axis_cell(pos_x, side);
      cy1 <= axis_cell(pos_y, side);
      cz1 <= axis_cell(pos_z, side);

      op2 <= op1;
      t2  <= SQ_W'(mul_x) + SQ_W'(cy1);
      cz2 <= cz1;

      op3 <= op2;
      if (op2.cmd == CMD_INSERT) begin
        addr3 <= cell_next;
      end else begin
        addr3 <= CELL_AW'(op2.query_cell);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/pclb_fifo.sv @@
// Small show-ahead queue that decouples the front from the store unit.
// No package dependency; used by the top level.
`default_nettype none

module pclb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ src/pclb_back.sv @@
// Back part: cell head/count store, particle link store and the result register.
// Depends on pclb_pkg; takes classified commands from the queue.
`default_nettype none

module pclb_back #(
  parameter int MAX_SIDE = 16,
  parameter int MAX_PARTICLES = 1024,
  localparam int NUM_CELLS = MAX_SIDE * MAX_SIDE * MAX_SIDE,
  localparam int CELL_AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1,
  localparam int LINK_AW = $clog2(MAX_PARTICLES)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  input  wire pclb_pkg::bin_op_t           q_op,
  input  wire logic [CELL_AW-1:0]          q_addr,
  output logic                             q_pop,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [pclb_pkg::CIDX_W-1:0]      cell_index,
  output logic                             link_valid,
  output logic [pclb_pkg::PID_W-1:0]       link_particle,
  output logic [pclb_pkg::CNT_W-1:0]       cell_count
);
  import pclb_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [PID_W-1:0]   head;
    logic [CNT_W-1:0]   count;
  } cell_entry_t;

  typedef struct packed {
    logic             valid;
    logic [PID_W-1:0] id;
  } link_entry_t;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  state_t              state;
  logic [CELL_AW-1:0]  clr_ptr;
  logic                clr_resume;
  logic [EPOCH_W-1:0]  epoch;
  bin_op_t             op;
  logic [CELL_AW-1:0]  addr_r;
  logic                out_valid;

  cell_entry_t         cell_mem [NUM_CELLS];
  link_entry_t         link_mem [MAX_PARTICLES];
  cell_entry_t         cell_rd, cell_wdata;
  link_entry_t         link_rd, link_wdata;
  logic                cell_we, link_we;
  logic [CELL_AW-1:0]  cell_raddr, cell_waddr;
  logic [LINK_AW-1:0]  link_raddr, link_waddr;

  logic                take, out_pop, wrap, ins_ok;
  logic                live, head_v;
  logic [CNT_W-1:0]    cur_cnt, cnt_inc;
  logic [CIDX_W-1:0]   res_cell;
  logic                res_lv;
  logic [PID_W-1:0]    res_lp;
  logic [CNT_W-1:0]    res_cnt;

  // Queue and result handshakes.
  assign out_pop = pop && out_valid;
  assign empty   = !out_valid;
  assign take    = (state == ST_IDLE) && !q_empty && (!out_valid || out_pop);
  assign q_pop   = take;
  assign wrap    = take && (q_op.cmd == CMD_INSERT) && q_op.new_frame && (epoch == '1);
  assign ins_ok  = (state == ST_EXEC) && (op.cmd == CMD_INSERT) && op.pid_ok;

  // Read addresses come from the queue head when a command is taken, else from the held one.
  assign cell_raddr = (state == ST_IDLE) ? q_addr : addr_r;
  assign link_raddr = (state == ST_IDLE) ? LINK_AW'(q_op.pid) : LINK_AW'(op.pid);

  // Write ports: the clearing sweep or the insert update.
  always_comb begin
    cell_we    = (state == ST_CLEAR) || ins_ok;
    cell_waddr = (state == ST_CLEAR) ? clr_ptr : addr_r;
    if (state == ST_CLEAR) begin
      cell_wdata = '0;
    end else begin
      cell_wdata.tag   = epoch;
      cell_wdata.head  = op.pid;
      cell_wdata.count = cnt_inc;
    end
    link_we          = ins_ok;
    link_waddr       = LINK_AW'(op.pid);
    link_wdata.valid = head_v;
    link_wdata.id    = cell_rd.head;
  end

  // Cell store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd <= cell_mem[cell_raddr];
  end

  // Link store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd <= link_mem[link_raddr];
  end

  // An entry counts only if it was written in the current frame.
  always_comb begin
    live    = cell_rd.tag == epoch;
    cur_cnt = live ? cell_rd.count : '0;
    head_v  = cur_cnt != '0;
    cnt_inc = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  end

  // Result of the command being carried out.
  always_comb begin
    res_cell = '0;
    res_lv   = 1'b0;
    res_lp   = '0;
    res_cnt  = '0;
    case (op.cmd)
      CMD_INSERT: begin
        res_cell = CIDX_W'(addr_r);
        if (op.pid_ok) begin
          res_lv  = head_v;
          res_lp  = head_v ? cell_rd.head : '0;
          res_cnt = cnt_inc;
        end else begin
          res_cnt = cur_cnt;
        end
      end
      CMD_READ_CELL: begin
        res_cell = op.query_cell;
        if (op.query_ok) begin
          res_lv  = head_v;
          res_lp  = head_v ? cell_rd.head : '0;
          res_cnt = cur_cnt;
        end
      end
      CMD_READ_LINK: begin
        if (op.pid_ok) begin
          res_lv = link_rd.valid;
          res_lp = link_rd.valid ? link_rd.id : '0;
        end
      end
      default: begin
        res_cell = '0;
      end
    endcase
  end

  // Sequencer: clearing sweep, command fetch, optional re-read, execute.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_ptr    <= '0;
      clr_resume <= 1'b0;
      epoch      <= EPOCH_FIRST;
      out_valid  <= 1'b0;
    end else begin
      if (out_pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_ptr == CELL_AW'(NUM_CELLS - 1)) begin
            clr_ptr <= '0;
            epoch   <= EPOCH_FIRST;
            state   <= clr_resume ? ST_READ : ST_IDLE;
          end else begin
            clr_ptr <= clr_ptr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (take) begin
            op     <= q_op;
            addr_r <= q_addr;
            if (wrap) begin
              clr_resume <= 1'b1;
              state      <= ST_CLEAR;
            end else begin
              if ((q_op.cmd == CMD_INSERT) && q_op.new_frame) begin
                epoch <= epoch + 1'b1;
              end
              state <= ST_EXEC;
            end
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          out_valid     <= 1'b1;
          cell_index    <= res_cell;
          link_valid    <= res_lv;
          link_particle <= res_lp;
          cell_count    <= res_cnt;
          clr_resume    <= 1'b0;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The result register is always free by the time a command executes.
  a_exec_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !out_valid)
    else $error("result register busy while a command executes");

  // The frame tag never reaches the value used by cleared entries.
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("frame tag reached zero");

  // A taken command either executes next or waits for a clearing sweep.
  a_take_next: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == ST_EXEC) || (state == ST_CLEAR))
    else $error("taken command neither executed nor swept");

  // No result appears during a clearing sweep.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CLEAR) && !out_valid) |=> !out_valid)
    else $error("result produced during clearing sweep");

endmodule

`default_nettype wire

@@ src/particle_cell_list_binning_unit.sv @@
// Top level of the particle cell-list binning unit: config register and wiring
// of front classifier, command queue and store unit. Depends on pclb_pkg.
//
//  Channel   Handshake          Payload
//  --------  -----------------  ------------------------------------------------
//  command   push / full        cmd, new_frame, particle_id, pos_x/y/z, query_cell
//  result    empty / pop        cell_index, link_valid, link_particle, cell_count
//  config    cfg_wen            cfg_wdata (cells per side)
//
// The front is a three-stage pipeline that takes one command per cycle while full
// is low. The store unit carries out each command as a read of the cell and link
// memories, then the update, and takes no new command until it is done with the
// last one. After reset the store unit sweeps all MAX_SIDE^3 cell entries (4096
// by default) before the first command executes; the same sweep runs again on
// every 63rd new frame. full rises when the queue and front pipeline are filled.
`default_nettype none

module particle_cell_list_binning_unit #(
  parameter int MAX_SIDE = 16,
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [pclb_pkg::CMD_W-1:0]        cmd,
  input  wire logic                              new_frame,
  input  wire logic [pclb_pkg::PID_W-1:0]        particle_id,
  input  wire logic signed [pclb_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [pclb_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [pclb_pkg::POS_W-1:0] pos_z,
  input  wire logic [pclb_pkg::QC_W-1:0]         query_cell,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [pclb_pkg::CIDX_W-1:0]            cell_index,
  output logic                                   link_valid,
  output logic [pclb_pkg::PID_W-1:0]             link_particle,
  output logic [pclb_pkg::CNT_W-1:0]             cell_count,
  input  wire logic                              cfg_wen,
  input  wire logic [pclb_pkg::CFG_W-1:0]        cfg_wdata
);
  import pclb_pkg::*;

  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int NUM_CELLS = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int Q_W       = $bits(bin_op_t) + CELL_AW;

  logic [CFG_W-1:0]   side_cfg;
  logic [SIDE_W-1:0]  side;
  logic               q_push, q_full, q_pop, q_empty;
  bin_op_t            f_op, b_op;
  logic [CELL_AW-1:0] f_addr, b_addr;

  // Cells-per-side register.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_cfg <= SIDE_RESET;
    end else if (cfg_wen) begin
      side_cfg <= cfg_wdata;
    end
  end

  // Side in use is the register clamped to the supported range.
  always_comb begin
    if (side_cfg == '0) begin
      side = SIDE_W'(1);
    end else if (int'(side_cfg) > MAX_SIDE) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(side_cfg);
    end
  end

  pclb_front #(
    .MAX_SIDE      (MAX_SIDE),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .new_frame   (new_frame),
    .particle_id (particle_id),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .query_cell  (query_cell),
    .side        (side),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_op        (f_op),
    .q_addr      (f_addr)
  );

  pclb_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_op, f_addr}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata ({b_op, b_addr}),
    .empty (q_empty)
  );

  pclb_back #(
    .MAX_SIDE      (MAX_SIDE),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_op          (b_op),
    .q_addr        (b_addr),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .cell_index    (cell_index),
    .link_valid    (link_valid),
    .link_particle (link_particle),
    .cell_count    (cell_count)
  );

endmodule

`default_nettype wire
